[hw/rtl/mpeg_sc_pkg.sv]
// Shared types, parse phase codes, header kind codes and the frame-rate table
// for the MPEG start-code header parser. No dependencies.
`timescale 1ns / 1ps

package mpeg_sc_pkg;

  // Parse phase codes.
  localparam logic [2:0] PH_SCAN = 3'd0;
  localparam logic [2:0] PH_CODE = 3'd1;
  localparam logic [2:0] PH_SEQ1 = 3'd2;
  localparam logic [2:0] PH_SEQ2 = 3'd3;
  localparam logic [2:0] PH_SEQ3 = 3'd4;
  localparam logic [2:0] PH_SEQ4 = 3'd5;
  localparam logic [2:0] PH_PIC1 = 3'd6;
  localparam logic [2:0] PH_PIC2 = 3'd7;

  // Header kind codes reported on the result channel.
  localparam logic [2:0] KIND_SEQ   = 3'd0;
  localparam logic [2:0] KIND_GOP   = 3'd1;
  localparam logic [2:0] KIND_PIC   = 3'd2;
  localparam logic [2:0] KIND_SLICE = 3'd3;
  localparam logic [2:0] KIND_OTHER = 3'd4;

  // Start code bytes.
  localparam logic [7:0] SC_SEQ    = 8'hB3;
  localparam logic [7:0] SC_GOP    = 8'hB8;
  localparam logic [7:0] SC_PIC    = 8'h00;
  localparam logic [7:0] SC_SLICE  = 8'h01;
  localparam logic [7:0] PFX_ZERO  = 8'h00;
  localparam logic [7:0] PFX_ONE   = 8'h01;

  typedef struct packed {
    logic [7:0] recent0;
    logic [7:0] recent1;
    logic [1:0] recent_count;
    logic [2:0] phase;
  } ctrl_t;

  typedef logic [2:0][7:0] hdr_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [2:0]  header_kind;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  rate_code;
    logic [15:0] rate_milli_fps;
    logic [2:0]  picture_kind;
  } result_t;

  // Frame rate in thousandths of a frame per second; undefined codes give 0.
  function automatic logic [15:0] milli_rate(input logic [3:0] code);
    logic [15:0] r;
    case (code)
      4'd1:    r = 16'd23976;
      4'd2:    r = 16'd24000;
      4'd3:    r = 16'd25000;
      4'd4:    r = 16'd29970;
      4'd5:    r = 16'd30000;
      4'd6:    r = 16'd50000;
      4'd7:    r = 16'd59940;
      4'd8:    r = 16'd60000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/mpeg_sc_step.sv]
// One parse step of the start-code parser: next window, phase and header
// bytes, and the result for one stream byte. Depends on mpeg_sc_pkg.
`timescale 1ns / 1ps

module mpeg_sc_step (
  input  logic [7:0]          data_byte_i,
  input  mpeg_sc_pkg::ctrl_t   ctrl_i,
  input  mpeg_sc_pkg::hdr_t    hdr_i,
  output mpeg_sc_pkg::ctrl_t   ctrl_o,
  output mpeg_sc_pkg::hdr_t    hdr_o,
  output logic                 emit_o,
  output mpeg_sc_pkg::result_t result_o
);
  import mpeg_sc_pkg::*;

  logic [2:0] seq_idx;

  assign seq_idx = ctrl_i.phase - PH_SEQ1;

  always_comb begin
    ctrl_o   = ctrl_i;
    hdr_o    = hdr_i;
    emit_o   = 1'b0;
    result_o = '0;
    unique case (ctrl_i.phase)
      PH_SCAN: begin
        if (ctrl_i.recent_count == 2'd0) begin
          ctrl_o.recent0      = data_byte_i;
          ctrl_o.recent_count = 2'd1;
        end else if (ctrl_i.recent_count == 2'd1) begin
          ctrl_o.recent1      = data_byte_i;
          ctrl_o.recent_count = 2'd2;
        end else if (ctrl_i.recent0 == PFX_ZERO && ctrl_i.recent1 == PFX_ZERO &&
                     data_byte_i == PFX_ONE) begin
          ctrl_o.phase        = PH_CODE;
          ctrl_o.recent_count = 2'd0;
        end else begin
          ctrl_o.recent0 = ctrl_i.recent1;
          ctrl_o.recent1 = data_byte_i;
        end
      end
      PH_CODE: begin
        if (data_byte_i == SC_SEQ) begin
          ctrl_o.phase = PH_SEQ1;
        end else if (data_byte_i == SC_PIC) begin
          ctrl_o.phase = PH_PIC1;
        end else begin
          emit_o              = 1'b1;
          result_o.start_code = data_byte_i;
          if (data_byte_i == SC_GOP) begin
            result_o.header_kind = KIND_GOP;
          end else if (data_byte_i == SC_SLICE) begin
            result_o.header_kind = KIND_SLICE;
          end else begin
            result_o.header_kind = KIND_OTHER;
          end
        end
      end
      PH_SEQ1, PH_SEQ2, PH_SEQ3: begin
        hdr_o[seq_idx[1:0]] = data_byte_i;
        ctrl_o.phase        = ctrl_i.phase + 3'd1;
      end
      PH_SEQ4: begin
        emit_o                  = 1'b1;
        result_o.start_code     = SC_SEQ;
        result_o.header_kind    = KIND_SEQ;
        result_o.frame_width    = {hdr_i[0], hdr_i[1][7:4]};
        result_o.frame_height   = {hdr_i[1][3:0], hdr_i[2]};
        result_o.rate_code      = data_byte_i[3:0];
        result_o.rate_milli_fps = milli_rate(data_byte_i[3:0]);
      end
      PH_PIC1: begin
        hdr_o[0]     = data_byte_i;
        ctrl_o.phase = PH_PIC2;
      end
      PH_PIC2: begin
        emit_o                = 1'b1;
        result_o.start_code   = SC_PIC;
        result_o.header_kind  = KIND_PIC;
        result_o.picture_kind = data_byte_i[5:3];
      end
      default: begin
        ctrl_o.phase = PH_SCAN;
      end
    endcase

    // Every report clears the window and restarts the prefix search.
    if (emit_o) begin
      ctrl_o.phase        = PH_SCAN;
      ctrl_o.recent_count = 2'd0;
    end
  end

endmodule

[hw/rtl/mpeg_start_code_header_parser.sv]
// MPEG start-code header parser: top level with the input register, the
// parse state, the result register and handshake control.
// Depends on mpeg_sc_pkg and mpeg_sc_step.
`timescale 1ns / 1ps

// How to use this block:
// The input channel carries one raw byte of an MPEG video stream per
// transaction (in_valid_i, in_stall_o, in_data_byte_i). The block looks for
// the 00 00 01 start prefix and, for each completed header, sends one
// transaction on the result channel (out_valid_o, out_stall_i and the field
// ports). Sequence headers report size and frame rate after their four
// extra bytes, picture headers report the coding type after two extra
// bytes, and all other codes are reported on the code byte itself. Most
// bytes produce no result at all.
// A byte accepted into the input register is parsed out of it, and its
// result, if any, is registered in the result register and presented on
// out_valid_o. Throughput is one byte per cycle while the receiver does not
// stall, set by the single parse step between the input and result registers.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more byte; in_stall_o rises only
// when both registers are full and the result is not being taken.
// Reset clears the window history, puts the parser back into prefix search
// and empties both registers. Header bytes collected before reset are not
// cleared, since they are always rewritten before they are used.
module mpeg_start_code_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_start_code_o,
  output logic [2:0]  out_header_kind_o,
  output logic [11:0] out_frame_width_o,
  output logic [11:0] out_frame_height_o,
  output logic [3:0]  out_rate_code_o,
  output logic [15:0] out_rate_milli_fps_o,
  output logic [2:0]  out_picture_kind_o
);
  import mpeg_sc_pkg::*;

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;

  // Parse state: window and phase are reset, header bytes are not.
  ctrl_t ctrl_q, ctrl_d;
  hdr_t  hdr_q, hdr_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  logic    in_fire;
  logic    advance;
  logic    step_fire;
  logic    emit;
  result_t result;

  // The held byte can be parsed whenever the result register is free or is
  // being emptied in this cycle.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step_fire  = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  mpeg_sc_step u_step (
    .data_byte_i (in_byte_q),
    .ctrl_i      (ctrl_q),
    .hdr_i       (hdr_q),
    .ctrl_o      (ctrl_d),
    .hdr_o       (hdr_d),
    .emit_o      (emit),
    .result_o    (result)
  );

  always_comb begin
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end

    if (step_fire && emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ctrl_q      <= '{recent0: 8'd0, recent1: 8'd0, recent_count: 2'd0, phase: PH_SCAN};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step_fire) begin
        ctrl_q <= ctrl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_data_byte_i;
    end
    if (step_fire) begin
      hdr_q <= hdr_d;
    end
    if (step_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_start_code_o     = out_q.start_code;
  assign out_header_kind_o    = out_q.header_kind;
  assign out_frame_width_o    = out_q.frame_width;
  assign out_frame_height_o   = out_q.frame_height;
  assign out_rate_code_o      = out_q.rate_code;
  assign out_rate_milli_fps_o = out_q.rate_milli_fps;
  assign out_picture_kind_o   = out_q.picture_kind;

  // The window never holds more than two bytes.
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.recent_count != 2'd3)
    else $error("window byte count out of range");

  // The input side stalls only while a byte is waiting to be parsed.
  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with an empty input register");

  // A report always restarts the prefix search with an empty window.
  a_emit_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && emit) |=> (ctrl_q.phase == PH_SCAN && ctrl_q.recent_count == 2'd0))
    else $error("parser did not restart after a report");

  // Only sequence headers carry a size, and they always carry code B3.
  a_seq_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_header_kind_o != KIND_SEQ) |->
      (out_frame_width_o == 12'd0 && out_frame_height_o == 12'd0 &&
       out_rate_milli_fps_o == 16'd0))
    else $error("size or rate reported for a non-sequence header");

  a_seq_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_header_kind_o == KIND_SEQ) |-> out_start_code_o == SC_SEQ)
    else $error("sequence header reported with wrong start code");

endmodule
